/* rtl/core/hwt_pkg.sv */
// ----------------------------------------------------------------------------
// hwt_pkg
// Shared widths, constants and register indexes of the heating-wire
// thermostat.
// ----------------------------------------------------------------------------
package hwt_pkg;

  localparam int ADC_BITS            = 12;
  localparam int RATIO_FRACTION_BITS = 16;
  localparam int RATIO_BITS          = 8 + RATIO_FRACTION_BITS;
  localparam int DEN_BITS            = ADC_BITS + 8;
  localparam int PROD_BITS           = ADC_BITS + 9;
  localparam int V_BITS              = 40;
  localparam int MUL_BITS            = 17;
  localparam int DIV_CNT_BITS        = $clog2(RATIO_BITS);
  localparam int STEP_CNT_BITS       = 8;
  localparam int TEMP_BITS           = 8;
  localparam int BAND_BITS           = 5;
  localparam int CORR_BITS           = 6;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 8;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_SETPOINT    = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_BAND_WARM   = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_BAND_HOT    = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_WIRE_LENGTH = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CORRECTION  = 3'd4;

  localparam logic [ADC_BITS-1:0]      PRESENCE_LIMIT = ADC_BITS'(50);
  localparam logic [ADC_BITS-1:0]      REF_LIMIT      = ADC_BITS'(50);
  localparam logic [TEMP_BITS-1:0]     WARM_LIMIT     = 8'd50;
  localparam logic [PROD_BITS-1:0]     WIRE_FACTOR    = PROD_BITS'(510);
  localparam logic [MUL_BITS-1:0]      STEP_UP_MUL    = 17'd63627;
  localparam logic [MUL_BITS-1:0]      STEP_DOWN_MUL  = 17'd67562;
  localparam logic [V_BITS-1:0]        ONE_Q32        = V_BITS'(64'h1_0000_0000);
  localparam logic [RATIO_BITS-1:0]    RATIO_ONE      = RATIO_BITS'(1) << RATIO_FRACTION_BITS;
  localparam logic [STEP_CNT_BITS-1:0] STEP_UP_MAX    = 8'd255;
  localparam logic [STEP_CNT_BITS-1:0] STEP_DOWN_MAX  = 8'd25;
  localparam int                       BASE_TEMP      = 25;

  localparam logic [TEMP_BITS-1:0] RST_SETPOINT    = 8'd45;
  localparam logic [BAND_BITS-1:0] RST_BAND_WARM   = 5'd3;
  localparam logic [BAND_BITS-1:0] RST_BAND_HOT    = 5'd1;
  localparam logic [7:0]           RST_WIRE_LENGTH = 8'd1;
  localparam logic [CORR_BITS-1:0] RST_CORRECTION  = 6'd0;

endpackage

/* rtl/core/hwt_if.sv */
// ----------------------------------------------------------------------------
// hwt_if
// Valid/ready channels of the heating-wire thermostat: sample items in,
// result items out.
// ----------------------------------------------------------------------------
interface hwt_in_if;
  logic                         valid;
  logic                         ready;
  logic [hwt_pkg::ADC_BITS-1:0] ref_sample;
  logic [hwt_pkg::ADC_BITS-1:0] wire_sample;
  logic [hwt_pkg::ADC_BITS-1:0] presence_sample;
  logic                         heater_enabled;
  logic                         heat_restart;

  modport source (output valid, ref_sample, wire_sample, presence_sample,
                  heater_enabled, heat_restart, input ready);
  modport sink (input valid, ref_sample, wire_sample, presence_sample,
                heater_enabled, heat_restart, output ready);
endinterface

interface hwt_out_if;
  logic                          valid;
  logic                          ready;
  logic [hwt_pkg::TEMP_BITS-1:0] temperature;
  logic                          heater_on;
  logic                          fault;

  modport source (output valid, temperature, heater_on, fault, input ready);
  modport sink (input valid, temperature, heater_on, fault, output ready);
endinterface

/* rtl/core/heater_wire_thermostat_top.sv */
// ----------------------------------------------------------------------------
// heater_wire_thermostat_top
// Wire temperature estimate and hysteresis heater control, one result per
// sample item.
// ----------------------------------------------------------------------------
// Each item on in_ch carries reference, wire and presence samples plus the
// enable and restart flags. For each item one result leaves on out_ch with
// the temperature, the heater drive and the fault flag.
// The block works on one item at a time and drops in_ch.ready from the
// acceptance until the result is loaded into the output register. The
// resistance ratio comes from a restoring divider that takes one quotient
// bit per cycle, and the temperature from a step loop that runs one
// constant multiply per cycle: up to about 190 steps for hot wires, up to
// 25 for cold ones. An item passes through the setup, check, divide,
// scale, step, temperature and finish states; the divider is skipped when
// the ratio saturates, and items rejected early (small reference, wire not
// above it) skip the divider and the step loop and go from the check
// straight to the temperature state.
// A finished result waits in the output register while out_ch.ready is low,
// and the next item is accepted meanwhile; its own result then waits until
// the register is free. Reset restores the register defaults, turns the
// heater off and clears the latched band and any pending restart. The user
// must write configuration through cfg_we, cfg_index and cfg_data while the
// block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module heater_wire_thermostat_top (
  input  logic                               clk,
  input  logic                               rst,
  hwt_in_if.sink                             in_ch,
  hwt_out_if.source                          out_ch,
  input  logic                               cfg_we,
  input  logic [hwt_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [hwt_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_SCALE = 3'd4;
  localparam logic [2:0] S_STEP  = 3'd5;
  localparam logic [2:0] S_TEMP  = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  logic [2:0] state;

  logic [hwt_pkg::TEMP_BITS-1:0] setpoint;
  logic [hwt_pkg::BAND_BITS-1:0] band_warm;
  logic [hwt_pkg::BAND_BITS-1:0] band_hot;
  logic [7:0]                    wire_length;
  logic [hwt_pkg::CORR_BITS-1:0] correction;

  logic                          heat_drive;
  logic [hwt_pkg::BAND_BITS-1:0] active_band;
  logic                          restart_pending;

  logic [hwt_pkg::ADC_BITS-1:0]      ref_r;
  logic [hwt_pkg::ADC_BITS-1:0]      wire_r;
  logic [hwt_pkg::ADC_BITS-1:0]      pres_r;
  logic                              enabled_r;
  logic                              restart_r;
  logic                              zero;
  logic [hwt_pkg::PROD_BITS-1:0]     prod;
  logic [hwt_pkg::DEN_BITS-1:0]      den;
  logic [hwt_pkg::DEN_BITS-1:0]      rem;
  logic [hwt_pkg::RATIO_BITS-1:0]    dq;
  logic [hwt_pkg::DIV_CNT_BITS-1:0]  div_cnt;
  logic [hwt_pkg::V_BITS-1:0]        v;
  logic                              up;
  logic                              first;
  logic [hwt_pkg::STEP_CNT_BITS-1:0] steps;
  logic [hwt_pkg::TEMP_BITS-1:0]     temp;

  logic                              out_valid;
  logic [hwt_pkg::TEMP_BITS-1:0]     out_temp;
  logic                              out_heat;
  logic                              out_fault;

  logic                                         in_fire;
  logic                                         out_free;
  logic [7:0]                                   len_eff;
  logic [hwt_pkg::DEN_BITS:0]                   trial;
  logic                                         trial_ge;
  logic [hwt_pkg::MUL_BITS-1:0]                 mul_k;
  logic [hwt_pkg::V_BITS+hwt_pkg::MUL_BITS-1:0] mul_p;
  logic                                         step_go;
  logic signed [10:0]                           t_sum;
  logic [hwt_pkg::TEMP_BITS-1:0]                t_sat;
  logic                                         fault_now;
  logic                                         pending_now;
  logic [hwt_pkg::BAND_BITS-1:0]                band_now;
  logic signed [9:0]                            low_now;
  logic                                         drive_next;

  assign in_ch.ready        = (state == S_IDLE);
  assign in_fire            = in_ch.valid && in_ch.ready;
  assign out_free           = !out_valid || out_ch.ready;
  assign out_ch.valid       = out_valid;
  assign out_ch.temperature = out_temp;
  assign out_ch.heater_on   = out_heat;
  assign out_ch.fault       = out_fault;

  assign len_eff  = (wire_length == 8'd0) ? 8'd1 : wire_length;
  assign trial    = {rem, dq[hwt_pkg::RATIO_BITS-1]};
  assign trial_ge = (trial >= {1'b0, den});
  assign mul_k    = up ? hwt_pkg::STEP_UP_MUL : hwt_pkg::STEP_DOWN_MUL;
  assign mul_p    = (hwt_pkg::V_BITS + hwt_pkg::MUL_BITS)'(v)
                  * (hwt_pkg::V_BITS + hwt_pkg::MUL_BITS)'(mul_k);

  always_comb begin
    if (first) begin
      step_go = 1'b1;
    end else if (up) begin
      step_go = (v > hwt_pkg::ONE_Q32) && (steps < hwt_pkg::STEP_UP_MAX);
    end else begin
      step_go = (v < hwt_pkg::ONE_Q32) && (steps < hwt_pkg::STEP_DOWN_MAX);
    end
  end

  always_comb begin
    if (up) begin
      t_sum = 11'(hwt_pkg::BASE_TEMP) + $signed({3'b000, steps});
    end else begin
      t_sum = 11'(hwt_pkg::BASE_TEMP) - $signed({3'b000, steps});
    end
    t_sum = t_sum - $signed({5'b00000, correction});
    if (zero || t_sum < 0) begin
      t_sat = '0;
    end else if (t_sum > 11'sd255) begin
      t_sat = 8'd255;
    end else begin
      t_sat = t_sum[7:0];
    end
  end

  always_comb begin
    fault_now   = (pres_r <= hwt_pkg::PRESENCE_LIMIT);
    pending_now = restart_pending || restart_r;
    if (pending_now) begin
      band_now = (temp > hwt_pkg::WARM_LIMIT) ? band_hot : band_warm;
    end else begin
      band_now = active_band;
    end
    low_now    = $signed({2'b00, setpoint}) - $signed({5'b00000, band_now});
    drive_next = heat_drive;
    if (fault_now || !enabled_r) begin
      drive_next = 1'b0;
    end else if (temp >= setpoint) begin
      drive_next = 1'b0;
    end else if ($signed({2'b00, temp}) <= low_now) begin
      drive_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint    <= hwt_pkg::RST_SETPOINT;
      band_warm   <= hwt_pkg::RST_BAND_WARM;
      band_hot    <= hwt_pkg::RST_BAND_HOT;
      wire_length <= hwt_pkg::RST_WIRE_LENGTH;
      correction  <= hwt_pkg::RST_CORRECTION;
    end else if (cfg_we) begin
      case (cfg_index)
        hwt_pkg::CFG_SETPOINT:    setpoint    <= cfg_data;
        hwt_pkg::CFG_BAND_WARM:   band_warm   <= cfg_data[hwt_pkg::BAND_BITS-1:0];
        hwt_pkg::CFG_BAND_HOT:    band_hot    <= cfg_data[hwt_pkg::BAND_BITS-1:0];
        hwt_pkg::CFG_WIRE_LENGTH: wire_length <= cfg_data;
        hwt_pkg::CFG_CORRECTION:  correction  <= cfg_data[hwt_pkg::CORR_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      heat_drive      <= 1'b0;
      active_band     <= '0;
      restart_pending <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (out_valid && out_ch.ready && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            ref_r     <= in_ch.ref_sample;
            wire_r    <= in_ch.wire_sample;
            pres_r    <= in_ch.presence_sample;
            enabled_r <= in_ch.heater_enabled;
            restart_r <= in_ch.heat_restart;
            state     <= S_SETUP;
          end
        end
        S_SETUP: begin
          zero  <= (ref_r < hwt_pkg::REF_LIMIT) || (wire_r <= ref_r);
          prod  <= hwt_pkg::PROD_BITS'(wire_r - ref_r) * hwt_pkg::WIRE_FACTOR;
          den   <= hwt_pkg::DEN_BITS'(ref_r) * hwt_pkg::DEN_BITS'(len_eff);
          up    <= 1'b0;
          steps <= '0;
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (zero) begin
            state <= S_TEMP;
          end else if (hwt_pkg::DEN_BITS'(prod >> 8) >= den) begin
            dq    <= '1;
            state <= S_SCALE;
          end else begin
            rem     <= hwt_pkg::DEN_BITS'(prod >> 8);
            dq      <= {prod[7:0], {hwt_pkg::RATIO_FRACTION_BITS{1'b0}}};
            div_cnt <= '0;
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          rem     <= trial_ge ? hwt_pkg::DEN_BITS'(trial - {1'b0, den})
                              : trial[hwt_pkg::DEN_BITS-1:0];
          dq      <= {dq[hwt_pkg::RATIO_BITS-2:0], trial_ge};
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == hwt_pkg::DIV_CNT_BITS'(hwt_pkg::RATIO_BITS - 1)) begin
            state <= S_SCALE;
          end
        end
        S_SCALE: begin
          v     <= hwt_pkg::V_BITS'(dq) << (32 - hwt_pkg::RATIO_FRACTION_BITS);
          up    <= (dq > hwt_pkg::RATIO_ONE);
          first <= 1'b1;
          if (dq == '0) begin
            zero  <= 1'b1;
            state <= S_TEMP;
          end else begin
            state <= S_STEP;
          end
        end
        S_STEP: begin
          if (step_go) begin
            v     <= mul_p[hwt_pkg::V_BITS+15:16];
            steps <= steps + 1'b1;
            first <= 1'b0;
          end else begin
            state <= S_TEMP;
          end
        end
        S_TEMP: begin
          temp  <= t_sat;
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_temp   <= temp;
            out_heat   <= drive_next;
            out_fault  <= fault_now;
            heat_drive <= drive_next;
            if (fault_now || !enabled_r) begin
              restart_pending <= pending_now;
            end else begin
              restart_pending <= 1'b0;
              active_band     <= band_now;
            end
            state <= S_IDLE;
          end else if (out_ch.ready) begin
            out_valid <= 1'b0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/hwt_checker.sv */
// ----------------------------------------------------------------------------
// hwt_checker
// Port-level checks of the heating-wire thermostat, bound to the top level.
// ----------------------------------------------------------------------------
module hwt_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [hwt_pkg::TEMP_BITS-1:0] temperature,
  input logic                          heater_on,
  input logic                          fault
);

  // A faulty sensor never comes with the heater driven.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(fault && heater_on))
    else $error("heater driven on a fault result");

  // One item at a time: the input closes right after an acceptance.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input still open after an item was accepted");

  // Reset leaves no result pending and the input open.
  assert property (@(posedge clk)
    rst |=> (!out_valid && in_ready))
    else $error("state after reset is wrong");

  // A stalled result holds its value.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(temperature) && $stable(heater_on) && $stable(fault)))
    else $error("stalled result changed");

endmodule

bind heater_wire_thermostat_top hwt_checker u_hwt_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .temperature (out_ch.temperature),
  .heater_on   (out_ch.heater_on),
  .fault       (out_ch.fault)
);
